### hdl/jkr_pkg.sv
// ----------------------------------------------------------------------------
// jkr_pkg
// Shared types and constants of the joystick key repeat unit.
// ----------------------------------------------------------------------------
package jkr_pkg;

  localparam int AXIS_W  = 10;
  localparam int TIME_W  = 16;
  localparam int DIR_W   = 3;
  localparam int DELAY_W = 8;
  localparam int CFG_IDX_W = 3;

  // delay mapping
  localparam logic [AXIS_W-1:0]  DEAD_ZONE  = 10'd80;
  localparam logic [DELAY_W-1:0] FAST_DELAY = 8'd15;
  localparam logic [DELAY_W-1:0] SLOW_DELAY = 8'd200;
  localparam logic [DELAY_W-1:0] DELAY_GAIN = 8'd185;   // slow minus fast

  // divider geometry
  localparam int NUM_W = AXIS_W + DELAY_W;              // 18-bit dividend
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'(NUM_W - 1);

  // tap codes
  localparam logic [DIR_W-1:0] KEY_LEFT   = 3'd0;
  localparam logic [DIR_W-1:0] KEY_UP     = 3'd1;
  localparam logic [DIR_W-1:0] KEY_DOWN   = 3'd2;
  localparam logic [DIR_W-1:0] KEY_RIGHT  = 3'd3;
  localparam logic [DIR_W-1:0] KEY_BUTTON = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_CENTRE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTRE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y = 3'd7;

  // lane result as seen by the merge logic
  typedef struct packed {
    logic               busy;
    logic               active;
    logic               neg;
    logic               pos;
    logic [DELAY_W-1:0] delay;
  } lane_stat_t;

  // one request worth of taps handed to the output queue
  typedef struct packed {
    logic             load;
    logic             btn;
    logic             x;
    logic             y;
    logic [DIR_W-1:0] x_dir;
    logic [DIR_W-1:0] y_dir;
  } tap_load_t;

endpackage

### hdl/jkr_axis_lane.sv
// ----------------------------------------------------------------------------
// jkr_axis_lane
// One axis: dead zone, span select and repeat delay by a restoring divider.
// ----------------------------------------------------------------------------
module jkr_axis_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [jkr_pkg::AXIS_W-1:0] sample,
  input  logic [jkr_pkg::AXIS_W-1:0] lo,
  input  logic [jkr_pkg::AXIS_W-1:0] mid,
  input  logic [jkr_pkg::AXIS_W-1:0] hi,
  output jkr_pkg::lane_stat_t        stat
);

  localparam int AW = jkr_pkg::AXIS_W;
  localparam int NW = jkr_pkg::NUM_W;
  localparam int DW = jkr_pkg::DELAY_W;

  logic signed [AW:0]   defl;
  logic signed [AW:0]   span;
  logic [AW-1:0]        mag;
  logic                 pos;
  logic                 neg;
  logic                 active;
  logic                 fast;
  logic [AW-1:0]        excess;
  logic [NW-1:0]        num;
  logic [AW:0]          den_wide;

  logic                 busy_r, busy_nxt;
  logic [jkr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]        rem_r, rem_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [AW-1:0]        den_r, den_nxt;
  logic [DW-1:0]        delay_r, delay_nxt;
  logic                 active_r, active_nxt;
  logic                 neg_r, neg_nxt;
  logic                 pos_r, pos_nxt;

  logic [AW:0]          trial;
  logic                 ge;
  logic [AW:0]          diff;
  logic [NW-1:0]        quo_step;

  always_comb begin
    defl     = $signed({1'b0, sample}) - $signed({1'b0, mid});
    neg      = defl[AW];
    pos      = !defl[AW] && (defl != '0);
    mag      = neg ? AW'(-defl) : defl[AW-1:0];
    span     = pos ? ($signed({1'b0, hi}) - $signed({1'b0, mid}))
                   : ($signed({1'b0, mid}) - $signed({1'b0, lo}));
    active   = (mag >= jkr_pkg::DEAD_ZONE);
    fast     = (span <= $signed({1'b0, jkr_pkg::DEAD_ZONE}));
    excess   = mag - jkr_pkg::DEAD_ZONE;
    num      = NW'(excess) * NW'(jkr_pkg::DELAY_GAIN);
    den_wide = (AW+1)'(span) - (AW+1)'(jkr_pkg::DEAD_ZONE);

    // one quotient bit a cycle
    trial    = {rem_r, quo_r[NW-1]};
    ge       = (trial >= {1'b0, den_r});
    diff     = trial - {1'b0, den_r};
    quo_step = {quo_r[NW-2:0], ge};
  end

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    den_nxt    = den_r;
    delay_nxt  = delay_r;
    active_nxt = active_r;
    neg_nxt    = neg_r;
    pos_nxt    = pos_r;
    if (start) begin
      active_nxt = active;
      neg_nxt    = neg;
      pos_nxt    = pos;
      rem_nxt    = '0;
      quo_nxt    = num;
      den_nxt    = den_wide[AW-1:0];
      cnt_nxt    = '0;
      if (!active) begin
        delay_nxt = '0;
      end else if (fast) begin
        delay_nxt = jkr_pkg::FAST_DELAY;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[AW-1:0] : trial[AW-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == jkr_pkg::DIV_LAST) begin
        busy_nxt = 1'b0;
        // quotient beyond the gain wraps below the fastest delay
        if (quo_step > NW'(jkr_pkg::DELAY_GAIN)) begin
          delay_nxt = jkr_pkg::FAST_DELAY;
        end else begin
          delay_nxt = jkr_pkg::SLOW_DELAY - quo_step[DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      active_r <= 1'b0;
      delay_r  <= '0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      delay_r  <= delay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    pos_r <= pos_nxt;
  end

  always_comb begin
    stat.busy   = busy_r;
    stat.active = active_r;
    stat.neg    = neg_r;
    stat.pos    = pos_r;
    stat.delay  = delay_r;
  end

endmodule

### hdl/jkr_tap_queue.sv
// ----------------------------------------------------------------------------
// jkr_tap_queue
// Merges button and axis taps of one request and drains them in order.
// ----------------------------------------------------------------------------
module jkr_tap_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jkr_pkg::tap_load_t        ld,
  output logic                      empty,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [jkr_pkg::DIR_W-1:0] out_key_dir,
  output logic                      out_last_of_run
);

  localparam int DRW = jkr_pkg::DIR_W;

  logic [1:0]     cnt_r, cnt_nxt;
  logic [DRW-1:0] e0_r, e1_r, e2_r;
  logic [DRW-1:0] e0_nxt, e1_nxt, e2_nxt;
  logic           pop;

  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    e2_nxt  = e2_r;
    if (ld.load && (cnt_r == 2'd0)) begin
      cnt_nxt = 2'(ld.btn) + 2'(ld.x) + 2'(ld.y);
      e0_nxt  = ld.btn ? jkr_pkg::KEY_BUTTON : (ld.x ? ld.x_dir : ld.y_dir);
      e1_nxt  = (ld.btn && ld.x) ? ld.x_dir : ld.y_dir;
      e2_nxt  = ld.y_dir;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      e0_nxt  = e1_r;
      e1_nxt  = e2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
  end

  assign empty           = (cnt_r == 2'd0);
  assign out_valid       = (cnt_r != 2'd0);
  assign out_key_dir     = e0_r;
  // the queue only ever holds one request's run
  assign out_last_of_run = (cnt_r == 2'd1);

endmodule

### hdl/joystick_key_repeat_unit.sv
// ----------------------------------------------------------------------------
// joystick_key_repeat_unit
// Joystick sample to key taps: button edge, X and Y auto-repeat by deflection.
// ----------------------------------------------------------------------------
// flow: an accepted request passes the axis lanes, dividing only where needed,
//   then ST_RUN and ST_LOAD; taps leave one a cycle while out_stall is low
// requests: in_stall holds off a new one until the last is in the tap queue;
//   each axis lane has an 18-step restoring divider; both lanes divide together
// reset: synchronous active-low; registers take their defaults, button history
//   and both tap timers clear to zero
// ----------------------------------------------------------------------------
module joystick_key_repeat_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jkr_pkg::AXIS_W-1:0]    in_x_sample,
  input  logic [jkr_pkg::AXIS_W-1:0]    in_y_sample,
  input  logic                          in_button_level,
  input  logic [jkr_pkg::TIME_W-1:0]    in_now_ms,
  // tap channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jkr_pkg::DIR_W-1:0]     out_key_dir,
  output logic                          out_last_of_run,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [jkr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jkr_pkg::AXIS_W-1:0]    cfg_wdata
);

  localparam int AW = jkr_pkg::AXIS_W;
  localparam int TW = jkr_pkg::TIME_W;

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a request
  localparam logic [1:0] ST_RUN  = 2'd1;   // lanes dividing
  localparam logic [1:0] ST_LOAD = 2'd2;   // waiting for the queue to drain

  logic [1:0] state_r, state_nxt;

  // configuration registers
  logic [AW-1:0] x_low_r, x_centre_r, x_high_r;
  logic [AW-1:0] y_low_r, y_centre_r, y_high_r;
  logic          invert_x_r, invert_y_r;

  // per-request state
  logic          prev_button_r;
  logic          btn_tap_r;
  logic [TW-1:0] now_r;
  logic [TW-1:0] x_last_r, x_last_nxt;
  logic [TW-1:0] y_last_r, y_last_nxt;

  logic                 accept;
  jkr_pkg::lane_stat_t  x_stat, y_stat;
  jkr_pkg::tap_load_t   ld;
  logic                 q_empty;
  logic [TW-1:0]        x_elapsed, y_elapsed;
  logic                 x_fire, y_fire;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // configuration write port, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r    <= 10'd45;
      x_centre_r <= 10'd516;
      x_high_r   <= 10'd930;
      y_low_r    <= 10'd85;
      y_centre_r <= 10'd516;
      y_high_r   <= 10'd970;
      invert_x_r <= 1'b0;
      invert_y_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        jkr_pkg::REG_X_LOW:    x_low_r    <= cfg_wdata;
        jkr_pkg::REG_X_CENTRE: x_centre_r <= cfg_wdata;
        jkr_pkg::REG_X_HIGH:   x_high_r   <= cfg_wdata;
        jkr_pkg::REG_Y_LOW:    y_low_r    <= cfg_wdata;
        jkr_pkg::REG_Y_CENTRE: y_centre_r <= cfg_wdata;
        jkr_pkg::REG_Y_HIGH:   y_high_r   <= cfg_wdata;
        jkr_pkg::REG_INVERT_X: invert_x_r <= cfg_wdata[0];
        jkr_pkg::REG_INVERT_Y: invert_y_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // two axis lanes work side by side on one request
  jkr_axis_lane u_x_lane (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .sample (in_x_sample),
    .lo     (x_low_r),
    .mid    (x_centre_r),
    .hi     (x_high_r),
    .stat   (x_stat)
  );

  jkr_axis_lane u_y_lane (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .sample (in_y_sample),
    .lo     (y_low_r),
    .mid    (y_centre_r),
    .hi     (y_high_r),
    .stat   (y_stat)
  );

  // timer check: elapsed time wraps at 16 bits, idle lanes carry delay zero
  always_comb begin
    x_elapsed = now_r - x_last_r;
    y_elapsed = now_r - y_last_r;
    x_fire    = x_stat.active && (x_elapsed > TW'(x_stat.delay));
    y_fire    = y_stat.active && (y_elapsed > TW'(y_stat.delay));
  end

  // control sequence
  always_comb begin
    state_nxt  = state_r;
    x_last_nxt = x_last_r;
    y_last_nxt = y_last_r;
    ld.load    = 1'b0;
    ld.btn     = btn_tap_r;
    ld.x       = x_fire;
    ld.y       = y_fire;
    // direction selection honors the invert bits
    ld.x_dir   = (invert_x_r ? x_stat.pos : x_stat.neg) ? jkr_pkg::KEY_LEFT
                                                         : jkr_pkg::KEY_RIGHT;
    ld.y_dir   = (invert_y_r ? y_stat.neg : y_stat.pos) ? jkr_pkg::KEY_UP
                                                         : jkr_pkg::KEY_DOWN;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!x_stat.busy && !y_stat.busy) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // hand over once the previous run is fully taken
        if (q_empty) begin
          ld.load   = 1'b1;
          state_nxt = ST_IDLE;
          if (x_fire) begin
            x_last_nxt = now_r;
          end
          if (y_fire) begin
            y_last_nxt = now_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prev_button_r <= 1'b0;
      btn_tap_r     <= 1'b0;
      x_last_r      <= '0;
      y_last_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      x_last_r <= x_last_nxt;
      y_last_r <= y_last_nxt;
      if (accept) begin
        // falling edge of the active-low button
        btn_tap_r     <= prev_button_r && !in_button_level;
        prev_button_r <= in_button_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now_ms;
    end
  end

  // merge stage: button, X, Y in that order
  jkr_tap_queue u_tap_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .ld              (ld),
    .empty           (q_empty),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_dir     (out_key_dir),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### tb/tb_joystick_key_repeat_unit.sv
// ----------------------------------------------------------------------------
// tb_joystick_key_repeat_unit
// Self-checking bench for the joystick key repeat unit: samples go in over
// the request channel, every tap that comes out is compared against a
// behavioral predictor of button edges and per-axis repeat timing, under
// random gaps and stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_joystick_key_repeat_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 40;    // covers the divide path
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SWEEP_ITEMS     = 33;
  localparam int AXIS_MAX        = (1 << jkr_pkg::AXIS_W) - 1;

  // one expected tap
  typedef struct packed {
    logic [jkr_pkg::DIR_W-1:0] dir;
    logic                      last;
  } tap_t;

  // dut inputs, all known from time zero
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [jkr_pkg::AXIS_W-1:0]    in_x_sample = '0;
  logic [jkr_pkg::AXIS_W-1:0]    in_y_sample = '0;
  logic                          in_button_level = 1'b1;
  logic [jkr_pkg::TIME_W-1:0]    in_now_ms = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [jkr_pkg::DIR_W-1:0]     out_key_dir;
  logic                          out_last_of_run;
  logic                          cfg_we = 1'b0;
  logic [jkr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [jkr_pkg::AXIS_W-1:0]    cfg_wdata = '0;

  // predictor copy of the registers, reset defaults
  int x_low_q = 45, x_mid_q = 516, x_high_q = 930;
  int y_low_q = 85, y_mid_q = 516, y_high_q = 970;
  bit swap_x = 1'b0, swap_y = 1'b0;

  // predictor copy of the tap history
  bit          btn_prev = 1'b0;
  logic [15:0] x_tap_ms = '0;
  logic [15:0] y_tap_ms = '0;

  tap_t taps_due[$];      // taps owed by the block, oldest first
  int   mismatches = 0;
  int   taps_seen = 0;
  int   cycle_count = 0;

  // stimulus knobs shared with the idling processes
  bit          tx_gaps_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_off_req = 1'b0;
  logic [15:0] clock_ms = '0;
  bit          btn_level = 1'b1;

  joystick_key_repeat_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_sample     (in_x_sample),
    .in_y_sample     (in_y_sample),
    .in_button_level (in_button_level),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_dir     (out_key_dir),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d taps still owed", taps_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [jkr_pkg::AXIS_W-1:0] clamp_axis(input int v);
    if (v < 0) return '0;
    if (v > AXIS_MAX) return jkr_pkg::AXIS_W'(AXIS_MAX);
    return jkr_pkg::AXIS_W'(v);
  endfunction

  // readings biased toward the dead zone edge and the rails
  function automatic int pick_axis(input int mid);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return mid + int'($urandom_range(0, 180)) - 90;
    if (r < 55) return $urandom_range(0, 60);
    if (r < 70) return AXIS_MAX - int'($urandom_range(0, 60));
    return $urandom_range(0, AXIS_MAX);
  endfunction

  // repeat delay in ms for one axis, zero while in the dead zone
  function automatic int repeat_delay_ms(input int defl, input int lo, input int mid,
                                         input int hi);
    int mag, span, delay;
    mag = (defl < 0) ? -defl : defl;
    if (mag < int'(jkr_pkg::DEAD_ZONE)) return 0;
    span = (defl > 0) ? hi - mid : mid - lo;
    // span inside the dead zone: fastest repeat
    if (span <= int'(jkr_pkg::DEAD_ZONE)) return int'(jkr_pkg::FAST_DELAY);
    delay = int'(jkr_pkg::SLOW_DELAY)
            - ((mag - int'(jkr_pkg::DEAD_ZONE)) * int'(jkr_pkg::DELAY_GAIN))
            / (span - int'(jkr_pkg::DEAD_ZONE));
    // past full scale the line would go below the fastest rate
    if (delay < int'(jkr_pkg::FAST_DELAY)) delay = int'(jkr_pkg::FAST_DELAY);
    return delay;
  endfunction

  // taps one accepted sample owes, in the order button, x, y
  task automatic predict_taps(input logic [jkr_pkg::AXIS_W-1:0] xs,
                              input logic [jkr_pkg::AXIS_W-1:0] ys,
                              input bit btn, input logic [jkr_pkg::TIME_W-1:0] t);
    int          dx, dy, x_delay, y_delay;
    logic [15:0] x_gone, y_gone;
    tap_t        run[$];
    tap_t        tap;
    dx = int'(xs) - x_mid_q;
    dy = int'(ys) - y_mid_q;
    x_delay = repeat_delay_ms(dx, x_low_q, x_mid_q, x_high_q);
    y_delay = repeat_delay_ms(dy, y_low_q, y_mid_q, y_high_q);
    tap.last = 1'b0;
    // falling edge of the active-low button
    if (!btn && btn_prev) begin
      tap.dir = jkr_pkg::KEY_BUTTON;
      run.push_back(tap);
    end
    btn_prev = btn;
    // elapsed time wraps with the 16-bit clock
    x_gone = t - x_tap_ms;
    if (x_delay > 0 && int'(x_gone) > x_delay) begin
      tap.dir = (swap_x ? (dx > 0) : (dx < 0)) ? jkr_pkg::KEY_LEFT : jkr_pkg::KEY_RIGHT;
      run.push_back(tap);
      x_tap_ms = t;
    end
    y_gone = t - y_tap_ms;
    if (y_delay > 0 && int'(y_gone) > y_delay) begin
      tap.dir = (swap_y ? (dy < 0) : (dy > 0)) ? jkr_pkg::KEY_UP : jkr_pkg::KEY_DOWN;
      run.push_back(tap);
      y_tap_ms = t;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) taps_due.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] tap %0d: %s, got %0d expected %0d", $realtime, taps_seen, what, got,
             want);
  endtask

  // one sample request; valid stays up afterwards so back-to-back requests
  // never drop it within a step
  task automatic send_sample(input logic [jkr_pkg::AXIS_W-1:0] xs,
                             input logic [jkr_pkg::AXIS_W-1:0] ys,
                             input bit btn, input logic [jkr_pkg::TIME_W-1:0] t);
    int gap;
    gap = tx_gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_x_sample     <= xs;
    in_y_sample     <= ys;
    in_button_level <= btn;
    in_now_ms       <= t;
    do @(posedge clk); while (in_stall);
    predict_taps(xs, ys, btn, t);
  endtask

  task automatic sample_after(input int dt, input int xs, input int ys, input bit btn);
    clock_ms = clock_ms + 16'(dt);
    send_sample(clamp_axis(xs), clamp_axis(ys), btn, clock_ms);
  endtask

  // all owed taps delivered and the divider surely finished
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (taps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [jkr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jkr_pkg::AXIS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register load while idle; invert writes carry junk above bit 0
  task automatic load_regs(input int xl, input int xc, input int xh, input int yl,
                           input int yc, input int yh, input bit ix, input bit iy);
    drain_idle();
    cfg_write(jkr_pkg::REG_X_LOW,    jkr_pkg::AXIS_W'(xl));
    cfg_write(jkr_pkg::REG_X_CENTRE, jkr_pkg::AXIS_W'(xc));
    cfg_write(jkr_pkg::REG_X_HIGH,   jkr_pkg::AXIS_W'(xh));
    cfg_write(jkr_pkg::REG_Y_LOW,    jkr_pkg::AXIS_W'(yl));
    cfg_write(jkr_pkg::REG_Y_CENTRE, jkr_pkg::AXIS_W'(yc));
    cfg_write(jkr_pkg::REG_Y_HIGH,   jkr_pkg::AXIS_W'(yh));
    cfg_write(jkr_pkg::REG_INVERT_X, {9'($urandom), ix});
    cfg_write(jkr_pkg::REG_INVERT_Y, {9'($urandom), iy});
    cfg_we <= 1'b0;
    x_low_q = xl & AXIS_MAX;
    x_mid_q = xc & AXIS_MAX;
    x_high_q = xh & AXIS_MAX;
    y_low_q = yl & AXIS_MAX;
    y_mid_q = yc & AXIS_MAX;
    y_high_q = yh & AXIS_MAX;
    swap_x = ix;
    swap_y = iy;
  endtask

  // ---------------------------------------------------------------------------
  // tap receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : tap_receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        n = gap_len() + 1;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // every accepted tap against the oldest owed one
  always @(posedge clk) begin : tap_check
    tap_t want;
    if (rst_n && out_valid && !out_stall) begin
      taps_seen++;
      if (taps_due.size() == 0) begin
        report_mismatch("tap with nothing owed, key", out_key_dir, -1);
      end else begin
        want = taps_due.pop_front();
        if (out_key_dir !== want.dir)
          report_mismatch("key_dir", out_key_dir, want.dir);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default registers: button history, dead zone edge, rails, timer edge, wrap
  task automatic test_default_map();
    sample_after(10, 516, 516, 0);       // pressed at start: no edge yet
    sample_after(10, 516, 516, 1);
    sample_after(10, 516, 516, 0);       // falling edge
    sample_after(10, 516, 516, 0);       // held, nothing
    sample_after(10, 595, 437, 1);       // one count inside the dead zone
    sample_after(250, 596, 436, 1);      // dead zone edge, slowest repeat
    sample_after(16, 1023, 1023, 0);     // button plus both axes
    sample_after(15, 1023, 1023, 1);     // elapsed equals delay: no tap
    sample_after(1, 0, 0, 0);            // beyond full scale, clamped
    sample_after(10, 930, 970, 1);
    clock_ms = 16'hFFF0;
    sample_after(0, 930, 85, 1);
    sample_after(20, 45, 970, 0);        // elapsed across the clock wrap
    sample_after(10, 516, 516, 1);       // zero deflection
  endtask

  // spans at or below the dead zone, one of them negative
  task automatic test_narrow_span();
    load_regs(500, 516, 560, 600, 516, 1023, 1'b0, 1'b0);
    sample_after(100, 700, 300, 1);
    sample_after(16, 300, 1023, 0);
    sample_after(16, 1023, 0, 1);
  endtask

  task automatic test_invert();
    load_regs(45, 516, 930, 85, 516, 970, 1'b1, 1'b1);
    sample_after(250, 1023, 1023, 0);
    sample_after(20, 0, 0, 1);
    sample_after(20, 700, 300, 0);
  endtask

  // registers at their extremes
  task automatic test_register_extremes();
    load_regs(0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
    sample_after(50, 1023, 1023, 1);
    sample_after(20, 0, 79, 0);
    load_regs(1023, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b0);
    sample_after(50, 0, 0, 1);
    sample_after(20, 1023, 944, 0);
  endtask

  // receiver holds off while samples keep coming, block must back up
  task automatic test_backpressure();
    load_regs(45, 516, 930, 85, 516, 970, 1'b0, 1'b0);
    tx_gaps_on = 1'b0;
    hold_off_req = 1'b1;
    for (int k = 0; k < 14; k++) begin
      btn_level = !btn_level;
      sample_after(40, (k % 2) ? 0 : 1023, (k % 3) ? 1023 : 0, btn_level);
    end
    tx_gaps_on = 1'b1;
  endtask

  // random samples under several register settings
  task automatic test_random_sweeps();
    int xc, yc, r;
    for (int ph = 0; ph < 4; ph++) begin
      xc = $urandom_range(100, 900);
      yc = $urandom_range(100, 900);
      case (ph)
        0: load_regs(0, 512, 1023, 0, 512, 1023, 1'b0, 1'b1);
        1: load_regs($urandom_range(0, xc), xc, $urandom_range(xc, AXIS_MAX),
                     $urandom_range(0, yc), yc, $urandom_range(yc, AXIS_MAX), 1'b1, 1'b0);
        2: load_regs($urandom_range(0, xc), xc, $urandom_range(xc, AXIS_MAX),
                     $urandom_range(0, yc), yc, $urandom_range(yc, AXIS_MAX),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: load_regs($urandom_range(0, AXIS_MAX), xc, $urandom_range(0, AXIS_MAX),
                           $urandom_range(0, AXIS_MAX), yc, $urandom_range(0, AXIS_MAX),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      // one sweep runs flat out with no idling on either side
      tx_gaps_on = (ph != 1);
      rx_idle_on = (ph != 1);
      for (int k = 0; k < SWEEP_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // regular sample cadence with realistic stick motion
          if ($urandom_range(0, 9) < 3) btn_level = !btn_level;
          sample_after($urandom_range(5, 40), pick_axis(x_mid_q), pick_axis(y_mid_q),
                       btn_level);
        end else if (r < 90) begin
          btn_level = 1'($urandom_range(0, 1));
          sample_after($urandom_range(0, 65535), $urandom_range(0, AXIS_MAX),
                       $urandom_range(0, AXIS_MAX), btn_level);
        end else begin
          // repeated timestamp
          btn_level = 1'($urandom_range(0, 1));
          sample_after(0, $urandom_range(0, AXIS_MAX), $urandom_range(0, AXIS_MAX),
                       btn_level);
        end
      end
      rx_idle_on = 1'b1;
      tx_gaps_on = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_default_map();
    test_narrow_span();
    test_invert();
    test_register_extremes();
    test_backpressure();
    test_random_sweeps();
    drain_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
